>>> sv/tpat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-phase average turn tracker.
// No dependencies; imported by every module of the block.
package tpat_pkg;

  localparam int unsigned SampleW = 12;
  localparam logic [SampleW-1:0] AvgMax = 12'hFFF;
  localparam logic [SampleW-1:0] MidLevelReset = 12'd2048;
  localparam logic [31:0] TurnStep = 32'd512;

  typedef enum logic [1:0] {
    SECTOR_NONE   = 2'd0,
    SECTOR_FIRST  = 2'd1,
    SECTOR_FOURTH = 2'd2
  } sector_t;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_ADD  = 2'd1,
    TURN_SUB  = 2'd2
  } turn_t;

  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] avg_one;
    logic [SampleW-1:0] avg_two;
  } win_t;

endpackage

>>> sv/tpat_acc.sv
`timescale 1ns / 1ps
// Input register, phase toggle, pair counter and the two phase sums.
// Presents each finished window's averages; depends on tpat_pkg.
module tpat_acc #(
  parameter int unsigned SAMPLE_PAIRS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic [tpat_pkg::SampleW-1:0] sample,
  input  logic                      slot_free,
  output tpat_pkg::win_t            win
);
  import tpat_pkg::*;

  localparam int unsigned SumW  = SampleW + $clog2(SAMPLE_PAIRS);
  localparam int unsigned CntW  = $clog2(SAMPLE_PAIRS + 1);
  localparam int unsigned Shift = $clog2(SAMPLE_PAIRS + 1) - 1;

  logic               s1_valid;
  logic [SampleW-1:0] s1_sample;
  logic               phase;
  logic [CntW-1:0]    pairs_left;
  logic [SumW-1:0]    sum_one;
  logic [SumW-1:0]    sum_two;

  logic            closes;
  logic            go;
  logic [SumW-1:0] sum_one_next;
  logic [SumW-1:0] sum_two_next;
  logic [SumW-1:0] shift_one;
  logic [SumW-1:0] shift_two;

  assign closes       = phase && (pairs_left == CntW'(1));
  assign go           = s1_valid && (!closes || slot_free);
  assign sample_stall = s1_valid && !go;

  assign sum_one_next = sum_one + SumW'(s1_sample);
  assign sum_two_next = sum_two + SumW'(s1_sample);
  assign shift_one    = sum_one >> Shift;
  assign shift_two    = sum_two_next >> Shift;

  always_comb begin
    win.valid   = go && closes;
    win.avg_one = (shift_one > SumW'(AvgMax)) ? AvgMax : shift_one[SampleW-1:0];
    win.avg_two = (shift_two > SumW'(AvgMax)) ? AvgMax : shift_two[SampleW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
    if (sample_valid && !sample_stall) begin
      s1_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 1'b0;
      pairs_left <= CntW'(SAMPLE_PAIRS);
      sum_one    <= '0;
      sum_two    <= '0;
    end else if (go) begin
      phase <= !phase;
      if (!phase) begin
        sum_one <= sum_one_next;
      end else if (closes) begin
        pairs_left <= CntW'(SAMPLE_PAIRS);
        sum_one    <= '0;
        sum_two    <= '0;
      end else begin
        pairs_left <= pairs_left - CntW'(1);
        sum_two    <= sum_two_next;
      end
    end
  end

endmodule

>>> sv/tpat_track.sv
`timescale 1ns / 1ps
// Mid-level register, sector classification, turn position and result register.
// Consumes window averages from tpat_acc; depends on tpat_pkg.
module tpat_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpat_pkg::SampleW-1:0] mid_level,
  input  tpat_pkg::win_t               win,
  output logic                         slot_free,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [tpat_pkg::SampleW-1:0] phase_one_average,
  output logic [tpat_pkg::SampleW-1:0] phase_two_average,
  output logic [1:0]                   sector_code,
  output logic [1:0]                   turn_event,
  output logic signed [31:0]           position
);
  import tpat_pkg::*;

  logic [SampleW-1:0] threshold;
  logic               in_first;
  logic               in_fourth;
  sector_t            sector;
  turn_t              turn;

  sector_t     sector_next;
  turn_t       turn_next;
  logic        in_first_next;
  logic        in_fourth_next;
  logic [31:0] position_next;

  assign cfg_ready         = 1'b1;
  assign slot_free         = !result_valid || !result_stall;
  assign sector_code       = sector;
  assign turn_event        = turn;

  always_comb begin
    sector_next    = SECTOR_NONE;
    turn_next      = TURN_NONE;
    in_first_next  = 1'b0;
    in_fourth_next = 1'b0;
    position_next  = position;
    if (win.avg_two >= threshold) begin
      if (win.avg_one >= threshold) begin
        if (in_fourth) begin
          position_next = position + TurnStep;
          turn_next     = TURN_ADD;
        end
        in_first_next = 1'b1;
        sector_next   = SECTOR_FIRST;
      end else begin
        if (in_first) begin
          position_next = position - TurnStep;
          turn_next     = TURN_SUB;
        end
        in_fourth_next = 1'b1;
        sector_next    = SECTOR_FOURTH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= MidLevelReset;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= mid_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      in_first     <= 1'b0;
      in_fourth    <= 1'b0;
      position     <= '0;
    end else if (win.valid) begin
      result_valid <= 1'b1;
      in_first     <= in_first_next;
      in_fourth    <= in_fourth_next;
      position     <= position_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win.valid) begin
      phase_one_average <= win.avg_one;
      phase_two_average <= win.avg_two;
      sector            <= sector_next;
      turn              <= turn_next;
    end
  end

endmodule

>>> sv/two_phase_average_turn_tracker.sv
`timescale 1ns / 1ps
// Top level of the two-phase average turn tracker.
// Instantiates tpat_acc and tpat_track; depends on tpat_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  sample   | sample_valid, sample_stall | sample
//  result   | result_valid, result_stall | phase_one/two_average, sector_code,
//           |                            | turn_event, position
//  cfg      | cfg_valid, cfg_ready       | mid_level
//
// One sample request per cycle while sample_stall is low; a window result
// follows its closing phase-two sample (input register, then result register).
// Reset clears the phase, sums, sector flags and position, reloads the pair
// counter with the full count and loads mid level 2048. A held result stalls
// the input only once the sample that closes the next window sits in the input
// register; samples before it keep flowing.
module two_phase_average_turn_tracker #(
  parameter int unsigned SAMPLE_PAIRS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [tpat_pkg::SampleW-1:0] sample,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpat_pkg::SampleW-1:0] mid_level,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [tpat_pkg::SampleW-1:0] phase_one_average,
  output logic [tpat_pkg::SampleW-1:0] phase_two_average,
  output logic [1:0]                   sector_code,
  output logic [1:0]                   turn_event,
  output logic signed [31:0]           position
);
  import tpat_pkg::*;

  win_t win;
  logic slot_free;

  tpat_acc #(
    .SAMPLE_PAIRS(SAMPLE_PAIRS)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .slot_free    (slot_free),
    .win          (win)
  );

  tpat_track u_track (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .mid_level         (mid_level),
    .win               (win),
    .slot_free         (slot_free),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .phase_one_average (phase_one_average),
    .phase_two_average (phase_two_average),
    .sector_code       (sector_code),
    .turn_event        (turn_event),
    .position          (position)
  );

endmodule

>>> sv/tpat_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the two-phase average turn tracker.
// Bound to two_phase_average_turn_tracker; depends on tpat_pkg.
module tpat_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [1:0]                   sector_code,
  input logic [1:0]                   turn_event,
  input logic signed [31:0]           position
);
  import tpat_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(position)
      && $stable(turn_event))
    else $error("held result changed");

  a_add: assert property (@(posedge clk) disable iff (rst)
    result_valid && (turn_event == TURN_ADD) |-> sector_code == SECTOR_FIRST)
    else $error("add turn outside first sector");

  a_sub: assert property (@(posedge clk) disable iff (rst)
    result_valid && (turn_event == TURN_SUB) |-> sector_code == SECTOR_FOURTH)
    else $error("subtract turn outside fourth sector");

  a_none: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sector_code == SECTOR_NONE) |-> turn_event == TURN_NONE)
    else $error("turn event with no sector");

endmodule

bind two_phase_average_turn_tracker tpat_checker u_tpat_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .sector_code  (sector_code),
  .turn_event   (turn_event),
  .position     (position)
);
